// File: design/pts_pkg.sv
// package for the priority thread scheduler
// shared constants, mode and status codes; no dependencies
package pts_pkg;
  localparam int unsigned ThreadSlots = 16;
  localparam int unsigned EventSlots  = 8;
  localparam int unsigned NoPriority  = 256;

  localparam logic [2:0] ModeTick      = 3'd0;
  localparam logic [2:0] ModeSchedule  = 3'd1;
  localparam logic [2:0] ModeAdd       = 3'd2;
  localparam logic [2:0] ModeKillId    = 3'd3;
  localparam logic [2:0] ModeKillSelf  = 3'd4;
  localparam logic [2:0] ModeSleep     = 3'd5;
  localparam logic [2:0] ModeBlock     = 3'd6;
  localparam logic [2:0] ModeAddEvent  = 3'd7;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusLast    = 2'd2;
  localparam logic [1:0] StatusNoThread = 2'd3;

  // best-so-far token handed along the cell chain
  typedef struct packed {
    logic       found;
    logic [7:0] prio;
    logic [5:0] slot;
  } best_t;
endpackage

// File: design/pts_cell.sv
// one thread slot cell: flags, priority, wake time, and a compare stage
// that updates the best-so-far token; uses pts_pkg
module pts_cell #(
  parameter int unsigned IdxW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            add_i,
  input  logic [7:0]      prio_i,
  input  logic            sleep_i,
  input  logic [31:0]     wake_i,
  input  logic            wake_chk_i,
  input  logic [31:0]     time_i,
  input  logic            blk_we_i,
  input  logic            blk_i,
  input  logic [IdxW-1:0] self_i,
  input  pts_pkg::best_t  best_i,
  output pts_pkg::best_t  best_o,
  output logic            alive_o
);
  logic alive_q, asleep_q, blocked_q;
  logic [7:0] prio_q;
  logic [31:0] wake_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
      asleep_q <= 1'b0;
      blocked_q <= 1'b0;
    end else begin
      if (clr_i) begin
        alive_q <= 1'b0;
        asleep_q <= 1'b0;
        blocked_q <= 1'b0;
      end else if (add_i) begin
        alive_q <= 1'b1;
        asleep_q <= 1'b0;
        blocked_q <= 1'b0;
      end else if (sleep_i) begin
        asleep_q <= 1'b1;
      end else if (wake_chk_i && alive_q && asleep_q && wake_q <= time_i) begin
        asleep_q <= 1'b0;
      end else if (blk_we_i) begin
        blocked_q <= blk_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_i) prio_q <= prio_i;
    if (sleep_i) wake_q <= wake_i;
  end

  always_comb begin
    best_o = best_i;
    if (alive_q && !asleep_q && !blocked_q && (!best_i.found || prio_q < best_i.prio)) begin
      best_o.found = 1'b1;
      best_o.prio = prio_q;
      best_o.slot = 6'(self_i);
    end
  end

  assign alive_o = alive_q;
endmodule

// File: design/pts_event.sv
// periodic event table with a sequential scan on tick
// uses pts_pkg
module pts_event #(
  parameter int unsigned EventSlots = pts_pkg::EventSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        add_i,
  input  logic [31:0] per_i,
  input  logic [31:0] start_i,
  input  logic        scan_i,
  input  logic [31:0] time_i,
  output logic        done_o,
  output logic        fired_o,
  output logic [2:0]  fidx_o,
  output logic        full_o,
  output logic [3:0]  slot_o
);
  localparam int unsigned EW = (EventSlots > 1) ? $clog2(EventSlots) : 1;
  localparam int unsigned CW = $clog2(EventSlots + 1);

  logic [31:0] per_q [EventSlots];
  logic [31:0] st_q [EventSlots];
  logic [31:0] el_q [EventSlots];
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic busy_q;
  logic hit;

  assign full_o = cnt_q >= CW'(EventSlots);
  assign slot_o = 4'(cnt_q);
  assign hit = st_q[idx_q[EW-1:0]] == time_i || el_q[idx_q[EW-1:0]] >= per_q[idx_q[EW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      busy_q <= 1'b0;
      done_o <= 1'b0;
      fired_o <= 1'b0;
      fidx_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (add_i && !full_o) cnt_q <= cnt_q + 1'b1;
      if (scan_i) begin
        busy_q <= 1'b1;
        idx_q <= '0;
        fired_o <= 1'b0;
        fidx_o <= '0;
      end else if (busy_q) begin
        if (idx_q >= cnt_q) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else if (hit) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
          fired_o <= 1'b1;
          fidx_o <= 3'(idx_q);
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_i && !full_o) begin
      per_q[cnt_q[EW-1:0]] <= per_i;
      st_q[cnt_q[EW-1:0]] <= start_i;
      el_q[cnt_q[EW-1:0]] <= '0;
    end else if (busy_q && idx_q < cnt_q) begin
      if (hit) el_q[idx_q[EW-1:0]] <= '0;
      else el_q[idx_q[EW-1:0]] <= el_q[idx_q[EW-1:0]] + 32'd1;
    end
  end
endmodule

// File: design/priority_thread_scheduler.sv
// top level of the priority thread scheduler
// uses pts_pkg, pts_cell, pts_event
// A request is taken when start_i is high and busy_o low; one result follows,
// shown for one cycle with done_o high; the receiver cannot stall it. A
// schedule request walks the best-so-far token through the chain of slot
// cells, one cell per cycle. A tick steps past each periodic event that does
// not fire, until one fires or the table ends.
module priority_thread_scheduler #(
  parameter int unsigned THREAD_SLOTS = pts_pkg::ThreadSlots,
  parameter int unsigned EVENT_SLOTS  = pts_pkg::EventSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  thread_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [31:0] duration_i,
  input  logic        block_flag_i,
  input  logic [31:0] event_period_i,
  input  logic [31:0] event_start_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  running_thread_o,
  output logic [3:0]  new_slot_o,
  output logic        event_fired_o,
  output logic [2:0]  fired_index_o,
  output logic [31:0] time_now_o
);
  localparam int unsigned IW = $clog2(THREAD_SLOTS);
  localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);
  localparam logic [2:0] StIdle = 3'd0, StExec = 3'd1, StScan = 3'd2,
                         StTick = 3'd3, StOut = 3'd4;

  logic [2:0] st_q;
  logic [2:0] mode_q;
  logic [3:0] tid_q;
  logic [7:0] prio_q;
  logic [31:0] dur_q;
  logic flag_q;
  logic [31:0] per_q, evs_q;
  logic [IW-1:0] cur_q;
  logic [CW-1:0] live_q;
  logic [31:0] time_q;
  logic [1:0] stat_q;
  logic [3:0] nslot_q;
  logic [IW-1:0] pos_q;
  logic [CW-1:0] steps_q;
  pts_pkg::best_t tok_q;

  logic [THREAD_SLOTS-1:0] alive;
  pts_pkg::best_t best_out [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] clr, add;
  logic exec;
  logic [IW-1:0] free_idx;
  logic free_any;
  logic tid_ok, cur_alive;
  logic ev_done, ev_fired, ev_full;
  logic [2:0] ev_fidx;
  logic [3:0] ev_slot;
  logic [1:0] stat_d;

  assign exec = st_q == StExec;
  assign tid_ok = (32'(tid_q) < THREAD_SLOTS) && alive[tid_q[IW-1:0]];
  assign cur_alive = alive[cur_q];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!alive[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    stat_d = pts_pkg::StatusOk;
    clr = '0;
    add = '0;
    unique case (mode_q)
      pts_pkg::ModeAdd: begin
        if (live_q >= CW'(THREAD_SLOTS) || !free_any) stat_d = pts_pkg::StatusFull;
        else add[free_idx] = 1'b1;
      end
      pts_pkg::ModeKillId: begin
        if (live_q == '0) stat_d = pts_pkg::StatusNoThread;
        else if (live_q == CW'(1)) stat_d = pts_pkg::StatusLast;
        else if (!tid_ok) stat_d = pts_pkg::StatusNoThread;
        else clr[tid_q[IW-1:0]] = 1'b1;
      end
      pts_pkg::ModeKillSelf: begin
        if (!cur_alive) stat_d = pts_pkg::StatusNoThread;
        else if (live_q <= CW'(1)) stat_d = pts_pkg::StatusLast;
        else clr[cur_q] = 1'b1;
      end
      pts_pkg::ModeSleep: if (!cur_alive) stat_d = pts_pkg::StatusNoThread;
      pts_pkg::ModeBlock: if (!tid_ok) stat_d = pts_pkg::StatusNoThread;
      pts_pkg::ModeAddEvent: if (ev_full) stat_d = pts_pkg::StatusFull;
      default: ;
    endcase
    if (!exec) begin
      clr = '0;
      add = '0;
    end
  end

  for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
    pts_cell #(.IdxW(IW)) u_cell (
      .clk_i, .rst_ni,
      .clr_i(clr[g]),
      .add_i(add[g]),
      .prio_i(prio_q),
      .sleep_i(exec && mode_q == pts_pkg::ModeSleep && cur_alive && cur_q == IW'(g)),
      .wake_i(time_q + dur_q),
      .wake_chk_i(st_q == StTick && steps_q == '0),
      .time_i(time_q),
      .blk_we_i(exec && mode_q == pts_pkg::ModeBlock && tid_ok && tid_q[IW-1:0] == IW'(g)),
      .blk_i(flag_q),
      .self_i(IW'(g)),
      .best_i(tok_q),
      .best_o(best_out[g]),
      .alive_o(alive[g])
    );
  end

  pts_event #(.EventSlots(EVENT_SLOTS)) u_event (
    .clk_i, .rst_ni,
    .add_i(exec && mode_q == pts_pkg::ModeAddEvent),
    .per_i(per_q),
    .start_i(evs_q),
    .scan_i(exec && mode_q == pts_pkg::ModeTick),
    .time_i(time_q),
    .done_o(ev_done),
    .fired_o(ev_fired),
    .fidx_o(ev_fidx),
    .full_o(ev_full),
    .slot_o(ev_slot)
  );

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      mode_q <= mode_i;
      tid_q <= thread_id_i;
      prio_q <= priority_req_i;
      dur_q <= duration_i;
      flag_q <= block_flag_i;
      per_q <= event_period_i;
      evs_q <= event_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cur_q <= '0;
      live_q <= '0;
      time_q <= '0;
      stat_q <= pts_pkg::StatusOk;
      nslot_q <= '0;
      pos_q <= '0;
      steps_q <= '0;
      tok_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (start_i) st_q <= StExec;
        StExec: begin
          stat_q <= stat_d;
          nslot_q <= '0;
          if (mode_q == pts_pkg::ModeAdd && stat_d == pts_pkg::StatusOk) begin
            live_q <= live_q + 1'b1;
            nslot_q <= 4'(free_idx);
          end
          if ((mode_q == pts_pkg::ModeKillId || mode_q == pts_pkg::ModeKillSelf)
              && stat_d == pts_pkg::StatusOk) live_q <= live_q - 1'b1;
          if (mode_q == pts_pkg::ModeAddEvent && stat_d == pts_pkg::StatusOk)
            nslot_q <= ev_slot;
          unique case (mode_q)
            pts_pkg::ModeTick: begin
              time_q <= time_q + 32'd1;
              steps_q <= '0;
              st_q <= StTick;
            end
            pts_pkg::ModeSchedule: begin
              tok_q <= '0;
              pos_q <= (cur_q == IW'(THREAD_SLOTS - 1)) ? '0 : cur_q + 1'b1;
              steps_q <= CW'(1);
              st_q <= StScan;
            end
            default: st_q <= StOut;
          endcase
        end
        StScan: begin
          if (steps_q == CW'(THREAD_SLOTS)) begin
            if (tok_q.found) cur_q <= tok_q.slot[IW-1:0];
            st_q <= StOut;
          end else begin
            tok_q <= best_out[pos_q];
            pos_q <= (pos_q == IW'(THREAD_SLOTS - 1)) ? '0 : pos_q + 1'b1;
            steps_q <= steps_q + 1'b1;
          end
        end
        StTick: begin
          steps_q <= CW'(1);
          if (ev_done) st_q <= StOut;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign busy_o = st_q != StIdle;
  assign done_o = st_q == StOut;
  assign status_o = stat_q;
  assign running_thread_o = 4'(cur_q);
  assign new_slot_o = nslot_q;
  assign event_fired_o = (mode_q == pts_pkg::ModeTick) ? ev_fired : 1'b0;
  assign fired_index_o = (mode_q == pts_pkg::ModeTick) ? ev_fidx : 3'd0;
  assign time_now_o = time_q;
endmodule
